// File: hdl/kct_pkg.sv
// Shared types, codes and key helper for the keyed count table.
`timescale 1ns / 1ps
`default_nettype none
package kct_pkg;
    localparam int DEF_CAPACITY  = 32;
    localparam int DEF_KEY_CHARS = 8;
    localparam int KEY_W         = 64;
    localparam int AMT_W         = 32;

    localparam logic [1:0] REQ_ADD = 2'd0;
    localparam logic [1:0] REQ_SUB = 2'd1;
    localparam logic [1:0] REQ_QRY = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;
    localparam logic [1:0] ST_SAT    = 2'd3;

    localparam logic [AMT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [KEY_W-1:0] key;
        logic [AMT_W-1:0] amount;
    } t_in;

    typedef struct packed {
        logic [1:0]       status;
        logic             found;
        logic [AMT_W-1:0] count_value;
        logic [4:0]       slot;
        logic [5:0]       entry_count;
    } t_out;

    function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] raw,
                                                  input int chars);
        logic [KEY_W-1:0] res;
        logic             alive;
        res   = '0;
        alive = 1'b1;
        for (int b = 0; b < 8; b++) begin
            if (b >= chars || raw[56-8*b +: 8] == 8'd0) begin
                alive = 1'b0;
            end
            if (alive) begin
                res[56-8*b +: 8] = raw[56-8*b +: 8];
            end
        end
        return res;
    endfunction
endpackage
`default_nettype wire

// File: hdl/kct_cam.sv
// Key cells: parallel compare, append and shift-down removal.
`timescale 1ns / 1ps
`default_nettype none
module kct_cam #(
    parameter int CAPACITY = 32,
    parameter int IDX_W    = $clog2(CAPACITY),
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  wire logic                     i_clk,
    input  wire logic [kct_pkg::KEY_W-1:0] i_key,
    input  wire logic [CNT_W-1:0]         i_count,
    input  wire logic                     i_append,
    input  wire logic                     i_remove,
    input  wire logic [IDX_W-1:0]         i_idx,
    output logic                          o_hit,
    output logic [IDX_W-1:0]              o_idx
);
    import kct_pkg::*;

    logic [KEY_W-1:0]    r_keys [CAPACITY];
    logic [CAPACITY-1:0] w_match;

    always_comb begin
        o_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_match[i] = (CNT_W'(i) < i_count) && (r_keys[i] == i_key);
            if (w_match[i]) begin
                o_idx = o_idx | IDX_W'(i);
            end
        end
        o_hit = |w_match;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            if (i_append && CNT_W'(i) == i_count) begin
                r_keys[i] <= i_key;
            end else if (i_remove && i < CAPACITY - 1 && IDX_W'(i) >= i_idx) begin
                r_keys[i] <= r_keys[(i < CAPACITY - 1) ? i + 1 : i];
            end
        end
    end
endmodule
`default_nettype wire

// File: hdl/keyed_count_table_unit.sv
// Keyed count table top level: key cells, count memory and request sequencer.
// Each item is looked up in the key cells (S_LOOK), then applied in S_UPD once
// the result register is free; new items are taken only in S_IDLE. A removal
// moves each later count down one slot, one read/write pair (S_SHR, S_SHW) each.
// Reset: synchronous active low; clears the entry count and control state.
// Key cells and count memory hold no reset value and are read only once written.
`timescale 1ns / 1ps
`default_nettype none
module keyed_count_table_unit #(
    parameter int CAPACITY  = kct_pkg::DEF_CAPACITY,
    parameter int KEY_CHARS = kct_pkg::DEF_KEY_CHARS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire kct_pkg::t_in  i_item,
    output logic               o_valid,
    input  wire logic          i_ready,
    output kct_pkg::t_out      o_item
);
    import kct_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {S_IDLE, S_LOOK, S_UPD, S_SHR, S_SHW} t_state;

    t_state           r_state;
    logic [1:0]       r_req;
    logic [KEY_W-1:0] r_key;
    logic [AMT_W-1:0] r_amt;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_end;
    logic [CNT_W-1:0] r_ptr;
    logic [IDX_W-1:0] r_idx;
    logic             r_hit;
    logic [AMT_W-1:0] r_rd;
    logic             r_out_valid;
    t_out             r_out;
    logic [AMT_W-1:0] r_mem [CAPACITY];

    logic             w_hit;
    logic [IDX_W-1:0] w_idx;
    logic             w_go;
    logic             w_append;
    logic             w_remove;
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic [AMT_W-1:0] w_wdata;
    logic             w_re;
    logic [IDX_W-1:0] w_raddr;
    logic [AMT_W:0]   w_sum;
    t_out             n_out;
    logic [CNT_W-1:0] n_count;

    kct_cam #(.CAPACITY(CAPACITY), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_cam (
        .i_clk    (i_clk),
        .i_key    (r_key),
        .i_count  (r_count),
        .i_append (w_append),
        .i_remove (w_remove),
        .i_idx    (r_idx),
        .o_hit    (w_hit),
        .o_idx    (w_idx)
    );

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_item  = r_out;
    assign w_go    = (r_state == S_UPD) && (!r_out_valid || i_ready);
    assign w_sum   = {1'b0, r_rd} + {1'b0, r_amt};

    always_comb begin
        n_out       = '0;
        n_out.found = r_hit;
        n_count     = r_count;
        w_append    = 1'b0;
        w_remove    = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_idx;
        w_wdata     = r_rd;
        case (r_req)
            REQ_ADD: begin
                if (r_hit) begin
                    w_we = 1'b1;
                    n_out.slot = 5'(r_idx);
                    if (w_sum[AMT_W]) begin
                        w_wdata      = COUNT_MAX;
                        n_out.status = ST_SAT;
                    end else begin
                        w_wdata = w_sum[AMT_W-1:0];
                    end
                    n_out.count_value = w_wdata;
                end else if (r_count == CNT_W'(CAPACITY)) begin
                    n_out.status = ST_FULL;
                end else begin
                    w_we              = 1'b1;
                    w_append          = 1'b1;
                    w_waddr           = r_count[IDX_W-1:0];
                    w_wdata           = r_amt;
                    n_out.count_value = r_amt;
                    n_out.slot        = 5'(r_count);
                    n_count           = r_count + 1'b1;
                end
            end
            REQ_SUB: begin
                if (!r_hit) begin
                    n_out.status = ST_ABSENT;
                end else begin
                    n_out.slot = 5'(r_idx);
                    if (r_rd <= r_amt) begin
                        w_remove = 1'b1;
                        n_count  = r_count - 1'b1;
                    end else begin
                        w_we              = 1'b1;
                        w_wdata           = r_rd - r_amt;
                        n_out.count_value = w_wdata;
                    end
                end
            end
            default: begin
                if (!r_hit) begin
                    n_out.status = ST_ABSENT;
                end else begin
                    n_out.count_value = r_rd;
                    n_out.slot        = 5'(r_idx);
                end
            end
        endcase
        n_out.entry_count = 6'(n_count);
        if (!w_go) begin
            w_append = 1'b0;
            w_remove = 1'b0;
            w_we     = 1'b0;
        end
        if (r_state == S_SHW) begin
            w_we    = 1'b1;
            w_waddr = r_ptr[IDX_W-1:0] - 1'b1;
            w_wdata = r_rd;
        end
        w_re    = (r_state == S_LOOK) || (r_state == S_SHR);
        w_raddr = (r_state == S_LOOK) ? w_idx : r_ptr[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_go) begin
                r_out       <= n_out;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_req   <= i_item.req_type;
                        r_key   <= norm_key(i_item.key, KEY_CHARS);
                        r_amt   <= i_item.amount;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_hit   <= w_hit;
                    r_idx   <= w_idx;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (w_go) begin
                        r_count     <= n_count;
                        r_end       <= r_count;
                        r_ptr       <= CNT_W'(r_idx) + 1'b1;
                        if (w_remove && CNT_W'(r_idx) + 1'b1 < r_count) begin
                            r_state <= S_SHR;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_SHR: begin
                    r_state <= S_SHW;
                end
                S_SHW: begin
                    r_ptr <= r_ptr + 1'b1;
                    if (r_ptr + 1'b1 < r_end) begin
                        r_state <= S_SHR;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// File: tb/keyed_count_table_checker.sv
// Checker for the keyed count table: predicts each result and compares it.
`timescale 1ns / 1ps
module keyed_count_table_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_ready_in,
    input  kct_pkg::t_in   i_item,
    input  logic           i_valid_out,
    input  logic           i_ready,
    input  kct_pkg::t_out  i_result,
    output int             o_errors,
    output int             o_pending,
    output int             o_results
);
    import kct_pkg::*;

    localparam int CAP = DEF_CAPACITY;

    logic [KEY_W-1:0] tbl_key [CAP];
    logic [AMT_W-1:0] tbl_cnt [CAP];
    int               tbl_used;
    t_out             expected_results[$];

    function automatic logic [KEY_W-1:0] key_canon(logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0] res;
        bit               alive;
        res   = '0;
        alive = 1;
        for (int b = 0; b < DEF_KEY_CHARS; b++) begin
            if (raw[56-8*b +: 8] == 8'd0) alive = 0;
            if (alive) res[56-8*b +: 8] = raw[56-8*b +: 8];
        end
        return res;
    endfunction

    function automatic t_out apply_request(t_in req);
        t_out             r;
        logic [KEY_W-1:0] k;
        logic [AMT_W-1:0] c;
        int               idx;
        k   = key_canon(req.key);
        idx = -1;
        r   = '0;
        for (int i = 0; i < tbl_used; i++) begin
            if (idx < 0 && tbl_key[i] == k) idx = i;
        end
        r.status = ST_OK;
        r.found  = (idx >= 0);
        if (req.req_type == REQ_ADD) begin
            if (idx >= 0) begin
                c = tbl_cnt[idx];
                if (req.amount > COUNT_MAX - c) begin
                    c = COUNT_MAX;
                    r.status = ST_SAT;
                end else begin
                    c = c + req.amount;
                end
                tbl_cnt[idx]  = c;
                r.count_value = c;
                r.slot        = idx[4:0];
            end else if (tbl_used >= CAP) begin
                r.status = ST_FULL;
            end else begin
                tbl_key[tbl_used] = k;
                tbl_cnt[tbl_used] = req.amount;
                r.count_value     = req.amount;
                r.slot            = tbl_used[4:0];
                tbl_used++;
            end
        end else if (req.req_type == REQ_SUB) begin
            if (idx < 0) begin
                r.status = ST_ABSENT;
            end else begin
                c      = tbl_cnt[idx];
                r.slot = idx[4:0];
                if (c <= req.amount) begin
                    for (int i = idx + 1; i < tbl_used; i++) begin
                        tbl_key[i-1] = tbl_key[i];
                        tbl_cnt[i-1] = tbl_cnt[i];
                    end
                    tbl_used--;
                end else begin
                    tbl_cnt[idx]  = c - req.amount;
                    r.count_value = c - req.amount;
                end
            end
        end else begin
            if (idx < 0) begin
                r.status = ST_ABSENT;
            end else begin
                r.count_value = tbl_cnt[idx];
                r.slot        = idx[4:0];
            end
        end
        r.entry_count = tbl_used[5:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            tbl_used  <= 0;
            o_errors  <= 0;
            o_results <= 0;
            expected_results.delete();
        end else begin
            if (i_valid && i_ready_in) expected_results.push_back(apply_request(i_item));
            if (i_valid_out && i_ready) begin
                o_results <= o_results + 1;
                if (expected_results.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result %p", i_result);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want !== i_result) begin
                        if (o_errors < 10)
                            $display("mismatch: expected %p actual %p", want, i_result);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

    assign o_pending = expected_results.size();
endmodule

// File: tb/keyed_count_table_unit_tb.sv
// Testbench top for the keyed count table: stimulus, idling and verdict.
`timescale 1ns / 1ps
module keyed_count_table_unit_tb;
    import kct_pkg::*;

    localparam int WATCHDOG = 20000;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic  i_clk = 0;
    logic  i_rst_n = 0;
    logic  i_valid = 0;
    logic  o_ready;
    t_in   i_item = '0;
    logic  o_valid;
    logic  i_ready = 0;
    t_out  o_item;
    int    errors, pending, results;
    int    send_idle_pct, recv_idle_pct;
    bit    recv_hold;
    int    quiet_cycles;
    logic [KEY_W-1:0] key_pool[16];

    always #1 i_clk = ~i_clk;

    keyed_count_table_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_item(i_item), .o_valid(o_valid), .i_ready(i_ready), .o_item(o_item)
    );

    keyed_count_table_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_ready_in(o_ready),
        .i_item(i_item), .i_valid_out(o_valid), .i_ready(i_ready), .i_result(o_item),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || recv_hold) i_ready <= 0;
        else i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG) begin
            $display("timeout");
            $display("status: fail");
            $finish;
        end
    end

    task automatic send(input logic [1:0] rt, input logic [KEY_W-1:0] k,
                        input logic [AMT_W-1:0] amt);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_item  <= '{req_type: rt, key: k, amount: amt};
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [KEY_W-1:0] rand_key();
        logic [KEY_W-1:0] k;
        k = {$urandom, $urandom};
        case ($urandom_range(3))
            0: k = key_pool[$urandom_range(15)];
            1: k = key_pool[$urandom_range(15)] | ({$urandom, $urandom} >> 8 * $urandom_range(1, 7)
                   & ~{64{1'b0}} & ({64{1'b1}} >> 8 * $urandom_range(1, 7)));
            default: ;
        endcase
        return k;
    endfunction

    function automatic logic [AMT_W-1:0] rand_amount();
        case ($urandom_range(5))
            0: return 0;
            1: return COUNT_MAX - $urandom_range(3);
            2: return $urandom;
            default: return $urandom_range(40);
        endcase
    endfunction

    task automatic random_phase(input int n, input int keyspan);
        int r;
        logic [1:0] rt;
        logic [KEY_W-1:0] k;
        for (int i = 0; i < n; i++) begin
            r  = $urandom_range(99);
            rt = r < 45 ? REQ_ADD : r < 80 ? REQ_SUB : r < 95 ? REQ_QRY : REQ_UNUSED;
            k  = ($urandom_range(9) < 8) ? key_pool[$urandom_range(keyspan - 1)] : rand_key();
            send(rt, k, rand_amount());
        end
    endtask

    initial begin
        logic [KEY_W-1:0] filler;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold     = 0;
        for (int i = 0; i < 16; i++)
            key_pool[i] = {8'h41 + i[7:0], 8'(i * 3), 48'h0}
                        | ({$urandom, $urandom} & {16'h0, 48'hFFFF_0000_0000} & {64{i[0]}});
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send(REQ_QRY, 64'h0, 0);
        send(REQ_SUB, 64'h4142_0000_0000_0000, 5);
        send(REQ_ADD, 64'h4142_0000_0000_0000, 0);
        send(REQ_ADD, 64'h4142_00FF_FFFF_FFFF, 7);
        send(REQ_ADD, 64'h4142_0000_0000_0000, COUNT_MAX);
        send(REQ_QRY, 64'h4142_0000_0000_0000, 0);
        send(REQ_ADD, 64'hFFFF_FFFF_FFFF_FFFF, COUNT_MAX);
        send(REQ_ADD, 64'h0, 1);
        send(REQ_SUB, 64'hFFFF_FFFF_FFFF_FFFF, 1);
        send(REQ_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        send(REQ_SUB, 64'h4142_0000_0000_0000, 2);
        send(REQ_SUB, 64'h4142_0000_0000_0000, COUNT_MAX);
        for (int i = 0; i < 32; i++) begin
            filler = {8'h30 + i[7:0], 56'h5A5A5A_5A5A5A5A};
            send(REQ_ADD, filler, i);
        end
        send(REQ_ADD, 64'h7A7A_0000_0000_0000, 1);
        send(REQ_SUB, 64'h30_5A5A5A_5A5A5A5A, 0);
        send(REQ_SUB, 64'h0, COUNT_MAX);
        send(REQ_ADD, 64'h7A7A_0000_0000_0000, 1);
        send(REQ_QRY, 64'h7A7A_0000_0000_0000, 0);
        drain();
        for (int i = 0; i < 32; i++) send(REQ_SUB, {8'h30 + i[7:0], 56'h5A5A5A_5A5A5A5A}, COUNT_MAX);
        send(REQ_SUB, 64'h7A7A_0000_0000_0000, COUNT_MAX);
        send(REQ_SUB, 64'h0, COUNT_MAX);
        send(REQ_SUB, 64'hFFFF_FFFF_FFFF_FFFF, COUNT_MAX);

        send_idle_pct = 35;
        recv_idle_pct = 83;
        random_phase(550, 16);

        drain();
        recv_hold = 1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                recv_hold = 0;
            end
            random_phase(30, 8);
        join

        send_idle_pct = 83;
        recv_idle_pct = 35;
        random_phase(550, 16);

        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 36; i++) send(REQ_ADD, {8'h61 + i[7:0], 56'h0}, $urandom_range(3));
        random_phase(600, 16);

        drain();
        repeat (200) @(posedge i_clk);
        $display("covered adds, subtracts, queries, removals, saturation and full table");
        $display("results checked: %0d, mismatches: %0d", results, errors);
        if (errors == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
